### hdl/slsi_pkg.sv
// shared types and codes for the sorted list insert/search block
// no dependencies; used by slsi_cell and sorted_list_insert_search
package slsi_pkg;

  localparam int ValW = 32;
  localparam int MaxResults = 16;

  typedef logic [1:0] func_t;
  localparam func_t FuncInsert = 2'd0;
  localparam func_t FuncSearch = 2'd1;
  localparam func_t FuncDump   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t StatusOk       = 2'd0;
  localparam status_t StatusFull     = 2'd1;
  localparam status_t StatusNotFound = 2'd2;
  localparam status_t StatusEmpty    = 2'd3;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

endpackage

### hdl/slsi_cell.sv
// one cell of the sorted chain: holds one entry and its occupied flag
// depends on slsi_pkg
module slsi_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slsi_pkg::cell_ctrl_t        ctrl_i,
  input  logic [slsi_pkg::ValW-1:0]   key_i,
  input  logic [slsi_pkg::ValW-1:0]   prev_value_i,
  input  logic                        prev_lt_i,
  input  logic                        prev_occ_i,
  input  logic                        prev_eq_i,
  input  logic [slsi_pkg::ValW-1:0]   next_value_i,
  input  logic                        next_occ_i,
  input  logic [slsi_pkg::ValW-1:0]   head_value_i,
  output logic [slsi_pkg::ValW-1:0]   value_o,
  output logic                        occ_o,
  output logic                        lt_o,
  output logic                        eq_o,
  output logic                        ins_here_o,
  output logic                        first_eq_o
);

  logic [slsi_pkg::ValW-1:0] value_q, value_d;
  logic                      occ_q, occ_d;

  assign lt_o       = occ_q && ($signed(value_q) < $signed(key_i));
  assign eq_o       = occ_q && (value_q == key_i);
  assign ins_here_o = !lt_o && prev_lt_i;
  assign first_eq_o = eq_o && !prev_eq_i;
  assign value_o    = value_q;
  assign occ_o      = occ_q;

  always_comb begin
    value_d = value_q;
    occ_d   = occ_q;
    if (ctrl_i.insert) begin
      occ_d = occ_q | prev_occ_i;
      if (!lt_o) begin
        value_d = prev_lt_i ? key_i : prev_value_i;
      end
    end else if (ctrl_i.rotate && occ_q) begin
      value_d = next_occ_i ? next_value_i : head_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### hdl/sorted_list_insert_search.sv
// sorted list insert/search/dump: top level with chain of slsi_cell
// insert and search: accept, then StExec, then the registered result strobe; no new item is taken while busy_o is high
// dump: results stream from the chain head as the occupied cells rotate
// full insert, search and empty dump give one result; func 3 gives none
// asynchronous active-low reset empties the list; the receiver cannot stall results
// depends on slsi_pkg and slsi_cell
module sorted_list_insert_search #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic signed [31:0] value_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [3:0]  position_o,
  output logic signed [31:0] entry_value_o,
  output logic [4:0]  count_o,
  output logic        last_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {StIdle, StExec, StDump} state_e;

  state_e                      state_q;
  logic [CntW-1:0]             count_q;
  logic [CntW-1:0]             dump_q;
  slsi_pkg::func_t             func_q;
  logic [slsi_pkg::ValW-1:0]   key_q;

  logic                        valid_q;
  slsi_pkg::status_t           status_q;
  logic [3:0]                  position_q;
  logic [slsi_pkg::ValW-1:0]   entry_q;
  logic [4:0]                  count_out_q;
  logic                        last_q;

  slsi_pkg::cell_ctrl_t        ctrl;
  logic [slsi_pkg::ValW-1:0]   cell_val [DEPTH];
  logic [DEPTH-1:0]            occ, lt, eq, ins_here, first_eq;

  logic [IdxW-1:0]             ins_pos, eq_pos;
  logic                        found;
  logic                        full;
  logic [31:0]                 ins_pos32, eq_pos32, dump32, cnt32, cnt_inc32, n_emit32;

  assign full = (count_q == CntW'(DEPTH));

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [slsi_pkg::ValW-1:0] prev_value, next_value;
    logic prev_lt, prev_occ, prev_eq, next_occ;
    if (k == 0) begin : g_head
      assign prev_value = key_q;
      assign prev_lt    = 1'b1;
      assign prev_occ   = 1'b1;
      assign prev_eq    = 1'b0;
    end else begin : g_body
      assign prev_value = cell_val[k-1];
      assign prev_lt    = lt[k-1];
      assign prev_occ   = occ[k-1];
      assign prev_eq    = eq[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign next_value = '0;
      assign next_occ   = 1'b0;
    end else begin : g_mid
      assign next_value = cell_val[k+1];
      assign next_occ   = occ[k+1];
    end
    slsi_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (key_q),
      .prev_value_i(prev_value),
      .prev_lt_i   (prev_lt),
      .prev_occ_i  (prev_occ),
      .prev_eq_i   (prev_eq),
      .next_value_i(next_value),
      .next_occ_i  (next_occ),
      .head_value_i(cell_val[0]),
      .value_o     (cell_val[k]),
      .occ_o       (occ[k]),
      .lt_o        (lt[k]),
      .eq_o        (eq[k]),
      .ins_here_o  (ins_here[k]),
      .first_eq_o  (first_eq[k])
    );
  end

  // one-hot to index encoders
  always_comb begin
    ins_pos = '0;
    eq_pos  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (ins_here[k]) ins_pos = ins_pos | IdxW'(k);
      if (first_eq[k]) eq_pos  = eq_pos | IdxW'(k);
    end
  end

  assign found     = |first_eq;
  assign ins_pos32 = 32'(ins_pos);
  assign eq_pos32  = 32'(eq_pos);
  assign dump32    = 32'(dump_q);
  assign cnt32     = 32'(count_q);
  assign cnt_inc32 = cnt32 + 32'd1;
  assign n_emit32  = (cnt32 > 32'(slsi_pkg::MaxResults)) ? 32'(slsi_pkg::MaxResults) : cnt32;

  always_comb begin
    ctrl = '0;
    if (state_q == StExec && func_q == slsi_pkg::FuncInsert && !full) ctrl.insert = 1'b1;
    if (state_q == StDump) ctrl.rotate = 1'b1;
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      dump_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q <= StIdle;
          dump_q  <= '0;
          unique case (func_q)
            slsi_pkg::FuncInsert: begin
              valid_q <= 1'b1;
              if (!full) count_q <= count_q + CntW'(1);
            end
            slsi_pkg::FuncSearch: valid_q <= 1'b1;
            slsi_pkg::FuncDump: begin
              if (count_q == '0) begin
                valid_q <= 1'b1;
              end else begin
                state_q <= StDump;
              end
            end
            default: ;
          endcase
        end
        StDump: begin
          valid_q <= (dump32 < 32'(slsi_pkg::MaxResults));
          if (dump_q == count_q - CntW'(1)) begin
            state_q <= StIdle;
          end else begin
            dump_q <= dump_q + CntW'(1);
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      func_q <= func_i;
      key_q  <= value_i;
    end
    count_out_q <= cnt32[4:0];
    last_q      <= 1'b1;
    entry_q     <= key_q;
    position_q  <= '0;
    status_q    <= slsi_pkg::StatusOk;
    unique case (state_q)
      StExec: begin
        unique case (func_q)
          slsi_pkg::FuncInsert: begin
            if (full) begin
              status_q <= slsi_pkg::StatusFull;
            end else begin
              position_q  <= ins_pos32[3:0];
              count_out_q <= cnt_inc32[4:0];
            end
          end
          slsi_pkg::FuncSearch: begin
            if (count_q == '0) begin
              status_q <= slsi_pkg::StatusEmpty;
            end else if (found) begin
              position_q <= eq_pos32[3:0];
            end else begin
              status_q <= slsi_pkg::StatusNotFound;
            end
          end
          slsi_pkg::FuncDump: begin
            status_q <= slsi_pkg::StatusEmpty;
            entry_q  <= '0;
          end
          default: ;
        endcase
      end
      StDump: begin
        entry_q    <= cell_val[0];
        position_q <= dump32[3:0];
        last_q     <= (dump32 + 32'd1 == n_emit32);
      end
      default: ;
    endcase
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign entry_value_o = entry_q;
  assign count_o       = count_out_q;
  assign last_o        = last_q;

  a_occ_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ) == 32'(count_q))
    else $error("occupied cells disagree with count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && func_q == slsi_pkg::FuncInsert && !full)
      |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the list");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o)
    else $error("final result while still busy");

  a_dump_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDump) |=> $stable(count_q))
    else $error("dump changed the count");

endmodule
